### rtl/core/vtp_pkg.sv
// Shared constants for the vertex transform and projection pipeline.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package vtp_pkg;

    // Input command codes.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_VERTEX = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FOCAL_X  = 2'd0;
    localparam logic [1:0] CFG_FOCAL_Y  = 2'd1;
    localparam logic [1:0] CFG_CENTER_X = 2'd2;
    localparam logic [1:0] CFG_CENTER_Y = 2'd3;

    // Matrix geometry: three linear rows plus one translation row.
    localparam int NUM_COEFS = 12;
    localparam int TRANS_BASE = 9;

    // Divider: quotient bits, bits per stage, stage count and the remainder and dividend widths.
    localparam int QBITS     = 10;
    localparam int QSTEP     = 2;
    localparam int QSTAGES   = QBITS / QSTEP;
    localparam int REM_W     = 43;
    localparam int NUM_W     = 66;
    // Cycles from divider input to its registered result.
    localparam int DIV_LAT   = QSTAGES + 4;

endpackage

### rtl/core/vtp_xform.sv
// Affine transform stage: matrix storage, nine products and the row sums.
// Depends on vtp_pkg.
`timescale 1ns / 1ps
module vtp_xform #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_acc,
    input  logic               i_cmd,
    input  logic [3:0]         i_coef_index,
    input  logic signed [31:0] i_coef_value,
    input  logic signed [31:0] i_vertex_x,
    input  logic signed [31:0] i_vertex_y,
    input  logic signed [31:0] i_vertex_z,
    output logic               o_valid,
    output logic signed [31:0] o_tx,
    output logic signed [31:0] o_ty,
    output logic signed [31:0] o_tz
);
    import vtp_pkg::*;

    logic signed [31:0] r_coef [NUM_COEFS];
    logic               r0_valid, r1_valid, r2_valid;
    logic signed [31:0] r0_v [3];
    logic signed [63:0] r1_p [9];
    logic signed [31:0] r1_tr [3];
    logic signed [31:0] r2_t [3];
    logic signed [31:0] n2_t [3];

    // Coefficient loads; reset gives identity with zero translation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEFS; i++) begin
                r_coef[i] <= ((i % 4) == 0 && i < TRANS_BASE) ?
                             32'(64'sd1 <<< FRAC_BITS) : 32'sd0;
            end
        end else if (i_acc && i_cmd == CMD_LOAD && i_coef_index < 4'(NUM_COEFS)) begin
            r_coef[i_coef_index] <= i_coef_value;
        end
    end

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r0_valid <= i_acc && i_cmd == CMD_VERTEX;
            r1_valid <= r0_valid;
            r2_valid <= r1_valid;
        end
    end

    // Stage 0 captures the vertex, stage 1 the products, stage 2 the sums.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_v[0] <= i_vertex_x;
            r0_v[1] <= i_vertex_y;
            r0_v[2] <= i_vertex_z;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r1_p[r*3+c] <= 64'(r0_v[r]) * 64'(r_coef[r*3+c]);
                end
            end
            for (int c = 0; c < 3; c++) begin
                r1_tr[c] <= r_coef[TRANS_BASE+c];
            end
            r2_t <= n2_t;
        end
    end

    // Floor each product, add the translation and saturate to 32 bits.
    always_comb begin
        logic signed [65:0] acc;
        for (int c = 0; c < 3; c++) begin
            acc = 66'(r1_tr[c]);
            for (int r = 0; r < 3; r++) begin
                acc = acc + 66'(r1_p[r*3+c] >>> FRAC_BITS);
            end
            if (acc > 66'sh7FFFFFFF) begin
                n2_t[c] = 32'sh7FFFFFFF;
            end else if (acc < -66'sh80000000) begin
                n2_t[c] = 32'sh80000000;
            end else begin
                n2_t[c] = acc[31:0];
            end
        end
    end

    assign o_valid = r2_valid;
    assign o_tx    = r2_t[0];
    assign o_ty    = r2_t[1];
    assign o_tz    = r2_t[2];

endmodule

### rtl/core/vtp_div.sv
// Pipelined projection divider for one screen axis: num / (tz * 2^F) + center.
// Depends on vtp_pkg; restoring division, two quotient bits per stage.
`timescale 1ns / 1ps
module vtp_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [63:0] i_num,
    input  logic               i_neg,
    input  logic signed [31:0] i_tz,
    input  logic [7:0]         i_center,
    output logic signed [7:0]  o_screen
);
    import vtp_pkg::*;

    logic signed [63:0]     ra_num;
    logic [31:0]            ra_d;
    logic signed [NUM_W-1:0] rb_n;
    logic [31:0]            rb_d;
    logic                   rb_low;
    logic [REM_W-1:0]       rs_rem [QSTAGES+1];
    logic [QBITS-1:0]       rs_q   [QSTAGES+1];
    logic [31:0]            rs_d   [QSTAGES+1];
    logic                   rs_lo  [QSTAGES+1];
    logic                   rs_hi  [QSTAGES+1];
    logic                   rs_low [QSTAGES+1];
    logic [REM_W-1:0]       n_rem  [QSTAGES];
    logic [QBITS-1:0]       n_q    [QSTAGES];
    logic signed [7:0]      r_screen;
    logic signed [7:0]      n_screen;
    logic signed [NUM_W-1:0] a_ext;

    // Fold both signs into the numerator; take the depth magnitude.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            ra_num <= i_neg ? -i_num : i_num;
            ra_d   <= i_tz[31] ? 32'(-i_tz) : 32'(i_tz);
        end
    end

    // Drop the fraction bits and bias the dividend by half the quotient range.
    assign a_ext = NUM_W'(ra_num >>> FRAC_BITS);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rb_n   <= a_ext + (NUM_W'(ra_d) <<< (QBITS - 1));
            rb_d   <= ra_d;
            rb_low <= |ra_num[FRAC_BITS-1:0];
        end
    end

    // Range checks; the divider only works inside [0, 2^QBITS * d).
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rs_lo[0]  <= rb_n[NUM_W-1];
            rs_hi[0]  <= !rb_n[NUM_W-1] &&
                         (rb_n[NUM_W-2:0] >= ((NUM_W-1)'(rb_d) << QBITS));
            rs_rem[0] <= rb_n[REM_W-1:0];
            rs_q[0]   <= '0;
            rs_d[0]   <= rb_d;
            rs_low[0] <= rb_low;
        end
    end

    // Restoring steps, QSTEP quotient bits per stage.
    for (genvar k = 0; k < QSTAGES; k++) begin : g_step
        always_comb begin
            logic [REM_W-1:0] dsh;
            n_rem[k] = rs_rem[k];
            n_q[k]   = rs_q[k];
            for (int j = 0; j < QSTEP; j++) begin
                dsh = REM_W'(rs_d[k]) << (QBITS - 1 - k*QSTEP - j);
                if (n_rem[k] >= dsh) begin
                    n_rem[k] = n_rem[k] - dsh;
                    n_q[k][QBITS-1-k*QSTEP-j] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                rs_rem[k+1] <= n_rem[k];
                rs_q[k+1]   <= n_q[k];
                rs_d[k+1]   <= rs_d[k];
                rs_lo[k+1]  <= rs_lo[k];
                rs_hi[k+1]  <= rs_hi[k];
                rs_low[k+1] <= rs_low[k];
            end
        end
    end

    // Unbias, add the center, truncate toward zero and saturate.
    always_comb begin
        logic signed [11:0] s;
        logic               rnz;
        rnz = (rs_rem[QSTAGES] != '0) || rs_low[QSTAGES];
        s   = $signed(12'(rs_q[QSTAGES])) - 12'sd512 + $signed({4'd0, i_center});
        if (s < 0 && rnz) begin
            s = s + 12'sd1;
        end
        if (rs_lo[QSTAGES]) begin
            n_screen = -8'sd128;
        end else if (rs_hi[QSTAGES] || s > 12'sd127) begin
            n_screen = 8'sd127;
        end else if (s < -12'sd128) begin
            n_screen = -8'sd128;
        end else begin
            n_screen = s[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_screen <= n_screen;
        end
    end

    assign o_screen = r_screen;

endmodule

### rtl/core/vertex_transform_project_top.sv
// Top level of the vertex transform and projection pipeline.
// Depends on vtp_pkg, vtp_xform and vtp_div.
`timescale 1ns / 1ps
// Usage:
// The input channel (i_valid / o_ready) takes one beat per cycle while o_ready
// is high. A beat with i_cmd low loads matrix coefficient i_coef_index (indexes
// above eleven are ignored) and gives no result. A beat with i_cmd high carries
// a vertex and gives exactly one result beat on the output channel (o_valid /
// i_ready). From the accepting edge to o_valid the vertex is registered at that
// edge, then passes two more transform stages, one of projection products, nine
// of the pipelined divider and the output register. Throughput is one vertex per
// cycle while the receiver does not stall; the divider resolves two quotient
// bits per stage so it never blocks.
// When the receiver stalls, the whole pipeline holds and o_ready falls, so
// nothing is lost or repeated. Configuration (focal lengths, centers) is
// written through i_cfg_we / i_cfg_index / i_cfg_data while the pipe is empty.
// Reset is synchronous, active low: the matrix returns to identity with zero
// translation, the remembered screen pair to zero and the registers to their
// defaults. A vertex whose transformed depth is zero repeats the last pair
// and raises o_depth_zero.
module vertex_transform_project_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_cmd,
    input  logic [3:0]         i_coef_index,
    input  logic signed [31:0] i_coef_value,
    input  logic signed [31:0] i_vertex_x,
    input  logic signed [31:0] i_vertex_y,
    input  logic signed [31:0] i_vertex_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [7:0]  o_screen_x,
    output logic signed [7:0]  o_screen_y,
    output logic signed [31:0] o_depth,
    output logic               o_depth_zero,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import vtp_pkg::*;

    logic               en, acc;
    logic signed [31:0] r_focal_x, r_focal_y;
    logic [7:0]         r_center_x, r_center_y;
    logic               x_valid;
    logic signed [31:0] x_tx, x_ty, x_tz;
    logic               r3_valid, r3_zero;
    logic signed [63:0] r3_px, r3_py;
    logic signed [31:0] r3_tz;
    logic               r_dl_valid [DIV_LAT];
    logic               r_dl_zero  [DIV_LAT];
    logic signed [31:0] r_dl_depth [DIV_LAT];
    logic signed [7:0]  div_sx, div_sy;
    logic signed [7:0]  r_last_x, r_last_y;
    logic               r_out_valid, r_out_zero;
    logic signed [7:0]  r_out_x, r_out_y;
    logic signed [31:0] r_out_depth;

    // Global advance: the pipe moves unless a finished beat is stuck.
    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;
    assign acc     = i_valid && en;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= 32'sd7503872;
            r_focal_y  <= 32'sd3751936;
            r_center_x <= 8'd64;
            r_center_y <= 8'd32;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FOCAL_X:  r_focal_x  <= i_cfg_data;
                CFG_FOCAL_Y:  r_focal_y  <= i_cfg_data;
                CFG_CENTER_X: r_center_x <= i_cfg_data[7:0];
                CFG_CENTER_Y: r_center_y <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    vtp_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_acc        (acc),
        .i_cmd        (i_cmd),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_vertex_x   (i_vertex_x),
        .i_vertex_y   (i_vertex_y),
        .i_vertex_z   (i_vertex_z),
        .o_valid      (x_valid),
        .o_tx         (x_tx),
        .o_ty         (x_ty),
        .o_tz         (x_tz)
    );

    // Projection numerators: transformed coordinate times focal length.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= x_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_px   <= 64'(x_tx) * 64'(r_focal_x);
            r3_py   <= 64'(x_ty) * 64'(r_focal_y);
            r3_tz   <= x_tz;
            r3_zero <= (x_tz == 32'sd0);
        end
    end

    // The y axis is mirrored, so its numerator sign is the opposite of x.
    vtp_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_num    (r3_px),
        .i_neg    (r3_tz[31]),
        .i_tz     (r3_tz),
        .i_center (r_center_x),
        .o_screen (div_sx)
    );

    vtp_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_num    (r3_py),
        .i_neg    (!r3_tz[31]),
        .i_tz     (r3_tz),
        .i_center (r_center_y),
        .o_screen (div_sy)
    );

    // Delay line that keeps valid, zero flag and depth beside the dividers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                r_dl_valid[i] <= 1'b0;
            end
        end else if (en) begin
            r_dl_valid[0] <= r3_valid;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_dl_valid[i] <= r_dl_valid[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dl_zero[0]  <= r3_zero;
            r_dl_depth[0] <= r3_tz;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_dl_zero[i]  <= r_dl_zero[i-1];
                r_dl_depth[i] <= r_dl_depth[i-1];
            end
        end
    end

    // Output register; a zero depth repeats the remembered screen pair.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_last_x    <= 8'sd0;
            r_last_y    <= 8'sd0;
        end else if (en) begin
            r_out_valid <= r_dl_valid[DIV_LAT-1];
            if (r_dl_valid[DIV_LAT-1] && !r_dl_zero[DIV_LAT-1]) begin
                r_last_x <= div_sx;
                r_last_y <= div_sy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_zero  <= r_dl_zero[DIV_LAT-1];
            r_out_depth <= r_dl_depth[DIV_LAT-1];
            r_out_x     <= r_dl_zero[DIV_LAT-1] ? r_last_x : div_sx;
            r_out_y     <= r_dl_zero[DIV_LAT-1] ? r_last_y : div_sy;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_screen_x   = r_out_x;
    assign o_screen_y   = r_out_y;
    assign o_depth      = r_out_depth;
    assign o_depth_zero = r_out_zero;

`ifndef SYNTHESIS
    // A zero-depth beat reports a depth of zero.
    a_zero_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_depth_zero |-> o_depth == 32'sd0)
        else $error("depth_zero set with nonzero depth");

    // The remembered pair always matches the beat on the output.
    a_last_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_screen_x == r_last_x && o_screen_y == r_last_y)
        else $error("remembered screen pair out of step with output");

    // Input is taken exactly when the output register can move.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready does not follow output stall");
`endif

endmodule

### verif/vtp_projection_checker.sv
// Checker for the vertex transform and projection block: predicts every result
// beat and compares it with what the block delivers. Depends on vtp_pkg.
`timescale 1ns / 1ps
module vtp_projection_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic               i_cmd,
    input  logic [3:0]         i_coef_index,
    input  logic signed [31:0] i_coef_value,
    input  logic signed [31:0] i_vertex_x,
    input  logic signed [31:0] i_vertex_y,
    input  logic signed [31:0] i_vertex_z,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic signed [7:0]  o_screen_x,
    input  logic signed [7:0]  o_screen_y,
    input  logic signed [31:0] o_depth,
    input  logic               o_depth_zero,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_pending
);
    import vtp_pkg::*;

    localparam int FRAC = 16;

    typedef struct {
        logic signed [7:0]  sx;
        logic signed [7:0]  sy;
        logic signed [31:0] depth;
        logic               zero;
    } t_screen_beat;

    t_screen_beat       screen_q[$];
    logic signed [31:0] coefs [NUM_COEFS];
    logic signed [7:0]  held_x;
    logic signed [7:0]  held_y;
    logic signed [31:0] focal_x;
    logic signed [31:0] focal_y;
    logic [7:0]         center_x;
    logic [7:0]         center_y;

    // Exact quotient num / (tz * 2^FRAC), plus center, truncated toward zero and saturated.
    function automatic logic signed [7:0] screen_coord(longint num, longint tz,
                                                       longint center);
        longint den;
        longint q;
        longint r;
        longint s;
        den = tz * (longint'(1) << FRAC);
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        q = num / den;
        r = num % den;
        if (r < 0) begin
            q = q - 1;
            r = r + den;
        end
        s = q + center;
        if (s < 0 && r != 0) s = s + 1;
        if (s < -128) s = -128;
        if (s > 127) s = 127;
        return s[7:0];
    endfunction

    // Row vector times matrix, each product floored, each coordinate saturated.
    function automatic longint xform_coord(int col);
        longint acc;
        acc = longint'(coefs[TRANS_BASE + col]);
        acc += (longint'(i_vertex_x) * longint'(coefs[col])) >>> FRAC;
        acc += (longint'(i_vertex_y) * longint'(coefs[3 + col])) >>> FRAC;
        acc += (longint'(i_vertex_z) * longint'(coefs[6 + col])) >>> FRAC;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        return acc;
    endfunction

    task automatic take_input_beat();
        longint       tx;
        longint       ty;
        longint       tz;
        t_screen_beat exp_beat;
        if (i_cmd != CMD_VERTEX) begin
            if (i_coef_index < NUM_COEFS) coefs[i_coef_index] = i_coef_value;
        end else begin
            tx = xform_coord(0);
            ty = xform_coord(1);
            tz = xform_coord(2);
            exp_beat.zero = (tz == 0);
            if (tz != 0) begin
                held_x = screen_coord(tx * longint'(focal_x), tz, longint'(center_x));
                held_y = screen_coord(-(ty * longint'(focal_y)), tz, longint'(center_y));
            end
            exp_beat.sx = held_x;
            exp_beat.sy = held_y;
            exp_beat.depth = tz[31:0];
            screen_q.push_back(exp_beat);
        end
    endtask

    task automatic check_output_beat();
        t_screen_beat exp_beat;
        if (screen_q.size() == 0) begin
            $display("%0t: unexpected result beat sx=%0d sy=%0d depth=%0d", $time,
                     o_screen_x, o_screen_y, o_depth);
            o_errors++;
        end else begin
            exp_beat = screen_q.pop_front();
            if (o_screen_x !== exp_beat.sx || o_screen_y !== exp_beat.sy ||
                o_depth !== exp_beat.depth || o_depth_zero !== exp_beat.zero) begin
                $display("%0t: mismatch expected sx=%0d sy=%0d depth=%0d zero=%0b",
                         $time, exp_beat.sx, exp_beat.sy, exp_beat.depth, exp_beat.zero);
                $display("%0t:          actual   sx=%0d sy=%0d depth=%0d zero=%0b",
                         $time, o_screen_x, o_screen_y, o_depth, o_depth_zero);
                o_errors++;
            end
        end
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

    // Sample at the falling edge: what is seen here is taken at the next rising edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COEFS; k++) coefs[k] = '0;
            coefs[0] = 32'sd65536;
            coefs[4] = 32'sd65536;
            coefs[8] = 32'sd65536;
            held_x = '0;
            held_y = '0;
            focal_x = 32'sd7503872;
            focal_y = 32'sd3751936;
            center_x = 8'd64;
            center_y = 8'd32;
            screen_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FOCAL_X:  focal_x = i_cfg_data;
                    CFG_FOCAL_Y:  focal_y = i_cfg_data;
                    CFG_CENTER_X: center_x = i_cfg_data[7:0];
                    CFG_CENTER_Y: center_y = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (o_valid && i_ready) check_output_beat();
            if (i_valid && o_ready) take_input_beat();
        end
        o_pending = screen_q.size();
    end

endmodule

### verif/tb_vertex_transform_project_top.sv
// Stimulus and verdict for the vertex transform and projection block.
// Depends on vtp_pkg, vertex_transform_project_top and vtp_projection_checker.
`timescale 1ns / 1ps
module tb_vertex_transform_project_top;
    import vtp_pkg::*;

    localparam int  MAX_CYCLES = 400000;
    localparam int  SETTLE = 40;
    localparam int  ONE = 65536;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic               i_cmd;
    logic [3:0]         i_coef_index;
    logic signed [31:0] i_coef_value;
    logic signed [31:0] i_vertex_x;
    logic signed [31:0] i_vertex_y;
    logic signed [31:0] i_vertex_z;
    logic               o_valid;
    logic               i_ready;
    logic signed [7:0]  o_screen_x;
    logic signed [7:0]  o_screen_y;
    logic signed [31:0] o_depth;
    logic               o_depth_zero;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;
    int                 fail_count;
    int                 pending;
    int                 cycle_count;
    logic               steady;

    vertex_transform_project_top dut (.*);

    vtp_projection_checker checker_i (
        .*,
        .o_errors  (fail_count),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver stalls about 13 times in a hundred, except in the steady stretch.
    always @(posedge i_clk) begin
        i_ready <= steady || ($urandom_range(99) >= 13);
    end

    // Mix of magnitudes so that the screen values land both inside and outside range.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return 32'sh7fffffff;
            2:       return 32'sh80000000;
            3:       return 0;
            4, 5:    return $signed($urandom_range(2 * ONE)) - ONE;
            default: return $signed($urandom_range(40 * ONE)) - 20 * ONE;
        endcase
    endfunction

    task automatic send_beat(logic cmd, logic [3:0] idx, logic signed [31:0] coef,
                             logic signed [31:0] vx, logic signed [31:0] vy,
                             logic signed [31:0] vz);
        logic taken;
        if (!steady && $urandom_range(99) < 13) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 40);
        end
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_coef_index <= idx;
        i_coef_value <= coef;
        i_vertex_x   <= vx;
        i_vertex_y   <= vy;
        i_vertex_z   <= vz;
        do begin
            @(negedge i_clk);
            taken = o_ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic load_coef(logic [3:0] idx, logic signed [31:0] value);
        send_beat(CMD_LOAD, idx, value, $urandom, $urandom, $urandom);
    endtask

    task automatic send_vertex(logic signed [31:0] vx, logic signed [31:0] vy,
                               logic signed [31:0] vz);
        send_beat(CMD_VERTEX, 4'($urandom), $urandom, vx, vy, vz);
    endtask

    // Let the pipe run empty before touching the registers.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++) begin
            steady = (n >= count / 3 && n < count / 3 + 80);
            if ($urandom_range(99) < 25) begin
                if ($urandom_range(9) == 0) load_coef(4'($urandom_range(15)), pick_value());
                else if ($urandom_range(3) == 0) load_coef(4'd11, 0);
                else load_coef(4'($urandom_range(11)), pick_value());
            end else if ($urandom_range(19) == 0) begin
                send_vertex(0, 0, 0);
            end else begin
                send_vertex(pick_value(), pick_value(), pick_value());
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        steady       = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_ready      = 1'b0;
        i_cmd        = CMD_LOAD;
        i_coef_index = '0;
        i_coef_value = '0;
        i_vertex_x   = '0;
        i_vertex_y   = '0;
        i_vertex_z   = '0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_FOCAL_X;
        i_cfg_data   = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero depth straight after reset repeats the reset pair.
        send_vertex(ONE, ONE, 0);
        send_vertex(ONE, 2 * ONE, 5 * ONE);
        send_vertex(-3 * ONE, ONE / 2, 2 * ONE);
        send_vertex(7, -9, 0);
        send_vertex(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        send_vertex(32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        send_vertex(100 * ONE, -100 * ONE, 1);
        send_vertex(0, 0, -1);
        // Coefficient extremes saturate the transform; indexes above eleven do nothing.
        load_coef(4'd0, 32'sh7fffffff);
        load_coef(4'd8, 32'sh80000000);
        load_coef(4'd12, 32'sh7fffffff);
        load_coef(4'd15, 32'sh80000000);
        send_vertex(32'sh7fffffff, ONE, 32'sh7fffffff);
        send_vertex(32'sh80000000, -ONE, 32'sh80000000);
        load_coef(4'd9, 10 * ONE);
        load_coef(4'd10, -5 * ONE);
        load_coef(4'd11, 3 * ONE);
        load_coef(4'd8, 0);
        send_vertex(0, 0, 0);
        send_vertex(ONE, ONE, ONE);
        load_coef(4'd11, 0);
        send_vertex(5 * ONE, 5 * ONE, 9 * ONE);
        drain();

        // Extreme register settings.
        write_reg(CFG_FOCAL_X, 32'h7fffffff);
        write_reg(CFG_FOCAL_Y, 32'h80000000);
        write_reg(CFG_CENTER_X, 32'd255);
        write_reg(CFG_CENTER_Y, 32'd0);
        random_phase(300);
        drain();

        write_reg(CFG_FOCAL_X, 32'h80000000);
        write_reg(CFG_FOCAL_Y, 32'h7fffffff);
        write_reg(CFG_CENTER_X, 32'd0);
        write_reg(CFG_CENTER_Y, 32'd255);
        random_phase(250);
        drain();

        // Random but moderate settings.
        write_reg(CFG_FOCAL_X, $urandom_range(200 * ONE));
        write_reg(CFG_FOCAL_Y, -$urandom_range(200 * ONE));
        write_reg(CFG_CENTER_X, $urandom);
        write_reg(CFG_CENTER_Y, $urandom);
        random_phase(250);
        drain();

        write_reg(CFG_FOCAL_X, $urandom);
        write_reg(CFG_FOCAL_Y, $urandom);
        write_reg(CFG_CENTER_X, 32'd64);
        write_reg(CFG_CENTER_Y, 32'd32);
        random_phase(250);
        drain();

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/vtp_pkg.sv
rtl/core/vtp_xform.sv
rtl/core/vtp_div.sv
rtl/core/vertex_transform_project_top.sv
verif/vtp_projection_checker.sv
verif/tb_vertex_transform_project_top.sv
